// File: src/gsla_pkg.sv
// shared widths, register codes and cordic table functions for the look angle block
package gsla_pkg;

  localparam int ANGLE_FRAC_BITS   = 16;
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ATAN_ROM_SIZE     = 32;

  localparam int POS_W      = 27;
  localparam int LAT_W      = 24;
  localparam int LON_W      = 25;
  localparam int MINEL_W    = 24;
  localparam int AZ_W       = 25;
  localparam int EL_W       = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  // internal angle: degrees * 2^32
  localparam int ANG_SH = 32;
  localparam int Z_W    = 41;
  localparam int RED_W  = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_LATITUDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ELEV  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;

  localparam real PI_R = 3.14159265358979323846;

  // atan(2^-i) in degrees * 2^32
  function automatic longint atan_deg(int i);
    real    a;
    longint q;
    if (i == 0) return longint'(45) << ANG_SH;
    a = $atan(2.0 ** (-i)) / PI_R * (2.0 ** 40);
    q = longint'(a);
    if (real'(q) > a) q = q - 1;
    return (q * 180 + 128) >>> 8;
  endfunction

  // squared cordic gain, Q60
  function automatic logic [63:0] cordic_k2(int n);
    logic [63:0] k;
    k = 64'd1 << 60;
    for (int i = 0; i < ATAN_ROM_SIZE; i++) begin
      if (i < n) k = k + (k >> (2 * i));
    end
    return k;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > rem) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

endpackage

// File: src/gsla_cordic.sv
// pipelined shift-add cordic, rotation or vectoring, one stage per iteration
module gsla_cordic #(
  parameter int STAGES    = gsla_pkg::CORDIC_STAGES_DEF,
  parameter int XY_W      = 36,
  parameter bit VECTORING = 1'b0,
  parameter int SIDE_W    = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic signed [XY_W-1:0]         in_x,
  input  logic signed [XY_W-1:0]         in_y,
  input  logic signed [gsla_pkg::Z_W-1:0] in_z,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic signed [XY_W-1:0]         out_x,
  output logic signed [XY_W-1:0]         out_y,
  output logic signed [gsla_pkg::Z_W-1:0] out_z,
  output logic [SIDE_W-1:0]              out_side
);
  import gsla_pkg::*;

  logic                  vc [STAGES+1];
  logic signed [XY_W-1:0] xc [STAGES+1];
  logic signed [XY_W-1:0] yc [STAGES+1];
  logic signed [Z_W-1:0]  zc [STAGES+1];
  logic [SIDE_W-1:0]      sc [STAGES+1];

  assign vc[0] = in_valid;
  assign xc[0] = in_x;
  assign yc[0] = in_y;
  assign zc[0] = in_z;
  assign sc[0] = in_side;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_deg(i));
    logic                   v_r;
    logic signed [XY_W-1:0] x_r;
    logic signed [XY_W-1:0] y_r;
    logic signed [Z_W-1:0]  z_r;
    logic [SIDE_W-1:0]      s_r;
    logic                   ccw;

    assign ccw = VECTORING ? (yc[i] < 0) : (zc[i] >= 0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= vc[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ccw) begin
        x_r <= xc[i] - (yc[i] >>> i);
        y_r <= yc[i] + (xc[i] >>> i);
        z_r <= zc[i] - ANG;
      end else begin
        x_r <= xc[i] + (yc[i] >>> i);
        y_r <= yc[i] - (xc[i] >>> i);
        z_r <= zc[i] + ANG;
      end
      s_r <= sc[i];
    end

    assign vc[i+1] = v_r;
    assign xc[i+1] = x_r;
    assign yc[i+1] = y_r;
    assign zc[i+1] = z_r;
    assign sc[i+1] = s_r;
  end

  assign out_valid = vc[STAGES];
  assign out_x     = xc[STAGES];
  assign out_y     = yc[STAGES];
  assign out_z     = zc[STAGES];
  assign out_side  = sc[STAGES];

endmodule

// File: src/ground_station_look_angles.sv
// ground station look angles: azimuth, elevation and visibility from an earth-fixed position
// pipeline: a request passes stage a, the sincos cordic pair, stages b to h, the azimuth cordic,
//   stages i and j, the elevation cordic and stage k; each cordic has CORDIC_STAGES stages, capped at ATAN_ROM_SIZE
// throughput: one request per cycle, busy stays low, results cannot be held off
// reset: synchronous active low, clears the valid bits and the configuration registers
module ground_station_look_angles #(
  parameter int CORDIC_STAGES = gsla_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [gsla_pkg::POS_W-1:0]   in_sat_x,
  input  logic signed [gsla_pkg::POS_W-1:0]   in_sat_y,
  input  logic signed [gsla_pkg::POS_W-1:0]   in_sat_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gsla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gsla_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  output logic signed [gsla_pkg::AZ_W-1:0]    out_azimuth,
  output logic signed [gsla_pkg::EL_W-1:0]    out_elevation,
  output logic                                out_in_view
);
  import gsla_pkg::*;

  localparam int NST  = (CORDIC_STAGES > ATAN_ROM_SIZE) ? ATAN_ROM_SIZE : CORDIC_STAGES;
  localparam int LAT  = 3 * NST + 10;
  localparam int SC_W = 33;
  localparam int GW   = 28;
  localparam int DW   = 30;
  localparam int PW   = SC_W + DW;
  localparam int CW   = 36;
  localparam int GR_W = 25;
  localparam int RE_W = 24;
  localparam int ROUND_SH = ANG_SH - ANGLE_FRAC_BITS;
  localparam int RND_W    = Z_W + 1 - ROUND_SH;

  localparam logic [63:0] KQ30     = isqrt64(cordic_k2(NST));
  localparam logic [63:0] GAIN_INV = (64'd1 << 60) / KQ30;
  localparam logic signed [SC_W-1:0] GAIN_Q30   = SC_W'(GAIN_INV);
  localparam logic signed [GR_W-1:0] GAIN_RANGE = GR_W'(GAIN_INV >> 6);
  localparam logic signed [RE_W-1:0] R_EARTH    = RE_W'(6371000);

  localparam logic signed [RED_W-1:0] ANG_FULL = RED_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [RED_W-1:0] ANG_HALF = RED_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [RED_W-1:0] ANG_QUAR = RED_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [Z_W-1:0]   DEG90_Z  = Z_W'(64'd90 << ANG_SH);
  localparam logic signed [Z_W:0]     RND_HALF = (Z_W + 1)'(1) <<< (ROUND_SH - 1);
  localparam logic signed [RND_W-1:0] AZ_LIM   = RND_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [RND_W-1:0] EL_LIM   = RND_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [Z_W-1:0]   RESID    = Z_W'(2 * atan_deg(NST - 1));

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    flip;
  } latside_t;

  typedef struct packed {
    logic signed [CW-1:0] u;
    logic                 zero;
  } azside_t;

  typedef struct packed {
    logic signed [Z_W-1:0] az;
    logic                  zero;
  } elside_t;

  typedef struct packed {
    logic                  flip;
    logic signed [Z_W-1:0] z;
  } red_t;

  function automatic red_t reduce_angle(logic signed [RED_W-1:0] v);
    logic signed [RED_W-1:0] r;
    red_t o;
    r = v;
    if (r > ANG_HALF) r = r - ANG_FULL;
    else if (r <= -ANG_HALF) r = r + ANG_FULL;
    o.flip = 1'b0;
    if (r > ANG_QUAR) begin
      r = r - ANG_HALF;
      o.flip = 1'b1;
    end else if (r < -ANG_QUAR) begin
      r = r + ANG_HALF;
      o.flip = 1'b1;
    end
    o.z = Z_W'(r) <<< ROUND_SH;
    return o;
  endfunction

  // configuration registers
  logic signed [LAT_W-1:0]   lat_r;
  logic signed [LON_W-1:0]   lon_r;
  logic signed [MINEL_W-1:0] min_el_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r    <= '0;
      lon_r    <= '0;
      min_el_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LATITUDE:  lat_r    <= cfg_data[LAT_W-1:0];
        CFG_LONGITUDE: lon_r    <= cfg_data[LON_W-1:0];
        CFG_MIN_ELEV:  min_el_r <= cfg_data[MINEL_W-1:0];
        CFG_UNUSED:    ;
        default:       ;
      endcase
    end
  end

  // stage a: capture request, reduce station angles
  red_t     lat_red;
  red_t     lon_red;
  logic     a_valid_r;
  latside_t a_side_r;
  logic signed [Z_W-1:0] a_zlat_r;
  logic signed [Z_W-1:0] a_zlon_r;
  logic     a_flip_lon_r;

  assign lat_red = reduce_angle(RED_W'(lat_r));
  assign lon_red = reduce_angle(RED_W'(lon_r));

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else        a_valid_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    a_side_r.x    <= in_sat_x;
    a_side_r.y    <= in_sat_y;
    a_side_r.z    <= in_sat_z;
    a_side_r.flip <= lat_red.flip;
    a_zlat_r      <= lat_red.z;
    a_zlon_r      <= lon_red.z;
    a_flip_lon_r  <= lon_red.flip;
  end

  // station sine and cosine
  logic                   lat_v, lon_v;
  logic signed [SC_W-1:0] lat_x, lat_y, lon_x, lon_y;
  logic signed [Z_W-1:0]  lat_z, lon_z;
  latside_t               lat_side;
  logic                   lon_flip;

  gsla_cordic #(
    .STAGES(NST), .XY_W(SC_W), .VECTORING(1'b0), .SIDE_W($bits(latside_t))
  ) u_sincos_lat (
    .clk(clk), .rst_n(rst_n), .in_valid(a_valid_r),
    .in_x(GAIN_Q30), .in_y('0), .in_z(a_zlat_r), .in_side(a_side_r),
    .out_valid(lat_v), .out_x(lat_x), .out_y(lat_y), .out_z(lat_z), .out_side(lat_side)
  );

  gsla_cordic #(
    .STAGES(NST), .XY_W(SC_W), .VECTORING(1'b0), .SIDE_W(1)
  ) u_sincos_lon (
    .clk(clk), .rst_n(rst_n), .in_valid(a_valid_r),
    .in_x(GAIN_Q30), .in_y('0), .in_z(a_zlon_r), .in_side(a_flip_lon_r),
    .out_valid(lon_v), .out_x(lon_x), .out_y(lon_y), .out_z(lon_z), .out_side(lon_flip)
  );

  // stage b: quadrant flip
  logic b_valid_r;
  logic signed [SC_W-1:0] b_sl_r, b_cl_r, b_so_r, b_co_r;
  latside_t b_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else        b_valid_r <= lat_v && lon_v;
  end

  always_ff @(posedge clk) begin
    b_sl_r  <= lat_side.flip ? -lat_y : lat_y;
    b_cl_r  <= lat_side.flip ? -lat_x : lat_x;
    b_so_r  <= lon_flip ? -lon_y : lon_y;
    b_co_r  <= lon_flip ? -lon_x : lon_x;
    b_sat_r <= lat_side;
  end

  // stage c: rotation matrix products
  logic c_valid_r;
  logic signed [2*SC_W-1:0] p_slco, p_slso, p_clco, p_clso;
  logic signed [SC_W-1:0] c_sl_r, c_cl_r, c_so_r, c_co_r;
  logic signed [SC_W-1:0] c_slco_r, c_slso_r, c_clco_r, c_clso_r;
  latside_t c_sat_r;

  assign p_slco = b_sl_r * b_co_r;
  assign p_slso = b_sl_r * b_so_r;
  assign p_clco = b_cl_r * b_co_r;
  assign p_clso = b_cl_r * b_so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else        c_valid_r <= b_valid_r;
  end

  always_ff @(posedge clk) begin
    c_slco_r <= p_slco[30 +: SC_W];
    c_slso_r <= p_slso[30 +: SC_W];
    c_clco_r <= p_clco[30 +: SC_W];
    c_clso_r <= p_clso[30 +: SC_W];
    c_sl_r   <= b_sl_r;
    c_cl_r   <= b_cl_r;
    c_so_r   <= b_so_r;
    c_co_r   <= b_co_r;
    c_sat_r  <= b_sat_r;
  end

  // stage d: station position, metres q2
  logic d_valid_r;
  logic signed [RE_W+SC_W-1:0] p_gx, p_gy, p_gz;
  logic signed [GW-1:0] d_gx_r, d_gy_r, d_gz_r;
  logic signed [SC_W-1:0] d_sl_r, d_cl_r, d_so_r, d_co_r;
  logic signed [SC_W-1:0] d_slco_r, d_slso_r, d_clco_r, d_clso_r;
  latside_t d_sat_r;

  assign p_gx = R_EARTH * c_clco_r;
  assign p_gy = R_EARTH * c_clso_r;
  assign p_gz = R_EARTH * c_sl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_valid_r <= 1'b0;
    else        d_valid_r <= c_valid_r;
  end

  always_ff @(posedge clk) begin
    d_gx_r   <= p_gx[28 +: GW];
    d_gy_r   <= p_gy[28 +: GW];
    d_gz_r   <= p_gz[28 +: GW];
    d_sl_r   <= c_sl_r;
    d_cl_r   <= c_cl_r;
    d_so_r   <= c_so_r;
    d_co_r   <= c_co_r;
    d_slco_r <= c_slco_r;
    d_slso_r <= c_slso_r;
    d_clco_r <= c_clco_r;
    d_clso_r <= c_clso_r;
    d_sat_r  <= c_sat_r;
  end

  // stage e: difference vector
  logic e_valid_r;
  logic signed [DW-1:0] e_dx_r, e_dy_r, e_dz_r;
  logic signed [SC_W-1:0] e_sl_r, e_cl_r, e_so_r, e_co_r;
  logic signed [SC_W-1:0] e_slco_r, e_slso_r, e_clco_r, e_clso_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_valid_r <= 1'b0;
    else        e_valid_r <= d_valid_r;
  end

  always_ff @(posedge clk) begin
    e_dx_r   <= (DW'(d_sat_r.x) <<< 2) - DW'(d_gx_r);
    e_dy_r   <= (DW'(d_sat_r.y) <<< 2) - DW'(d_gy_r);
    e_dz_r   <= (DW'(d_sat_r.z) <<< 2) - DW'(d_gz_r);
    e_sl_r   <= d_sl_r;
    e_cl_r   <= d_cl_r;
    e_so_r   <= d_so_r;
    e_co_r   <= d_co_r;
    e_slco_r <= d_slco_r;
    e_slso_r <= d_slso_r;
    e_clco_r <= d_clco_r;
    e_clso_r <= d_clso_r;
  end

  // stage f: enu products
  logic f_valid_r;
  logic signed [PW-1:0] f_p_r [8];

  always_ff @(posedge clk) begin
    if (!rst_n) f_valid_r <= 1'b0;
    else        f_valid_r <= e_valid_r;
  end

  always_ff @(posedge clk) begin
    f_p_r[0] <= PW'(-e_so_r) * PW'(e_dx_r);
    f_p_r[1] <= PW'(e_co_r) * PW'(e_dy_r);
    f_p_r[2] <= PW'(-e_slco_r) * PW'(e_dx_r);
    f_p_r[3] <= PW'(-e_slso_r) * PW'(e_dy_r);
    f_p_r[4] <= PW'(e_cl_r) * PW'(e_dz_r);
    f_p_r[5] <= PW'(e_clco_r) * PW'(e_dx_r);
    f_p_r[6] <= PW'(e_clso_r) * PW'(e_dy_r);
    f_p_r[7] <= PW'(e_sl_r) * PW'(e_dz_r);
  end

  // stage g: enu sums, metres q4
  logic g_valid_r;
  logic signed [PW+1:0] s_e, s_n, s_u;
  logic signed [CW-1:0] g_e_r, g_n_r, g_u_r;

  assign s_e = (PW + 2)'(f_p_r[0]) + (PW + 2)'(f_p_r[1]);
  assign s_n = (PW + 2)'(f_p_r[2]) + (PW + 2)'(f_p_r[3]) + (PW + 2)'(f_p_r[4]);
  assign s_u = (PW + 2)'(f_p_r[5]) + (PW + 2)'(f_p_r[6]) + (PW + 2)'(f_p_r[7]);

  always_ff @(posedge clk) begin
    if (!rst_n) g_valid_r <= 1'b0;
    else        g_valid_r <= f_valid_r;
  end

  always_ff @(posedge clk) begin
    g_e_r <= s_e[28 +: CW];
    g_n_r <= s_n[28 +: CW];
    g_u_r <= s_u[28 +: CW];
  end

  // stage h: quadrant pre-rotation for azimuth
  logic h_valid_r;
  logic signed [CW-1:0] h_x_nxt, h_y_nxt, h_x_r, h_y_r;
  logic signed [Z_W-1:0] h_z_nxt, h_z_r;
  azside_t h_side_r;

  always_comb begin
    h_x_nxt = g_n_r;
    h_y_nxt = g_e_r;
    h_z_nxt = '0;
    if (g_n_r < 0) begin
      if (g_e_r >= 0) begin
        h_x_nxt = g_e_r;
        h_y_nxt = -g_n_r;
        h_z_nxt = DEG90_Z;
      end else begin
        h_x_nxt = -g_e_r;
        h_y_nxt = g_n_r;
        h_z_nxt = -DEG90_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) h_valid_r <= 1'b0;
    else        h_valid_r <= g_valid_r;
  end

  always_ff @(posedge clk) begin
    h_x_r         <= h_x_nxt;
    h_y_r         <= h_y_nxt;
    h_z_r         <= h_z_nxt;
    h_side_r.u    <= g_u_r;
    h_side_r.zero <= (g_e_r == 0) && (g_n_r == 0);
  end

  logic                  az_v;
  logic signed [CW-1:0]  az_x, az_y;
  logic signed [Z_W-1:0] az_z;
  azside_t               az_side;

  gsla_cordic #(
    .STAGES(NST), .XY_W(CW), .VECTORING(1'b1), .SIDE_W($bits(azside_t))
  ) u_atan_az (
    .clk(clk), .rst_n(rst_n), .in_valid(h_valid_r),
    .in_x(h_x_r), .in_y(h_y_r), .in_z(h_z_r), .in_side(h_side_r),
    .out_valid(az_v), .out_x(az_x), .out_y(az_y), .out_z(az_z), .out_side(az_side)
  );

  // stage i: gain correction of horizontal range
  logic i_valid_r;
  logic signed [CW+GR_W-1:0] i_prod_r;
  logic signed [Z_W-1:0] i_az_r;
  logic signed [CW-1:0] i_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) i_valid_r <= 1'b0;
    else        i_valid_r <= az_v;
  end

  always_ff @(posedge clk) begin
    i_prod_r <= (CW + GR_W)'(az_x) * (CW + GR_W)'(GAIN_RANGE);
    i_az_r   <= az_side.zero ? '0 : az_z;
    i_u_r    <= az_side.u;
  end

  // stage j: elevation cordic input
  logic j_valid_r;
  logic signed [CW-1:0] j_h, j_h_r, j_u_r;
  elside_t j_side_r;

  assign j_h = i_prod_r[24 +: CW];

  always_ff @(posedge clk) begin
    if (!rst_n) j_valid_r <= 1'b0;
    else        j_valid_r <= i_valid_r;
  end

  always_ff @(posedge clk) begin
    j_h_r         <= j_h;
    j_u_r         <= i_u_r;
    j_side_r.az   <= i_az_r;
    j_side_r.zero <= (i_u_r == 0) && (j_h == 0);
  end

  logic                  el_v;
  logic signed [CW-1:0]  el_x, el_y;
  logic signed [Z_W-1:0] el_z;
  elside_t               el_side;

  gsla_cordic #(
    .STAGES(NST), .XY_W(CW), .VECTORING(1'b1), .SIDE_W($bits(elside_t))
  ) u_atan_el (
    .clk(clk), .rst_n(rst_n), .in_valid(j_valid_r),
    .in_x(j_h_r), .in_y(j_u_r), .in_z('0), .in_side(j_side_r),
    .out_valid(el_v), .out_x(el_x), .out_y(el_y), .out_z(el_z), .out_side(el_side)
  );

  // stage k: round, clamp, threshold
  logic signed [Z_W-1:0]   el_zs;
  logic signed [Z_W:0]     az_rnd, el_rnd;
  logic signed [RND_W-1:0] az_q, el_q, az_c, el_c;
  logic out_valid_r;
  logic signed [AZ_W-1:0] out_az_r;
  logic signed [EL_W-1:0] out_el_r;
  logic out_view_r;

  assign el_zs  = el_side.zero ? '0 : el_z;
  assign az_rnd = (Z_W + 1)'(el_side.az) + RND_HALF;
  assign el_rnd = (Z_W + 1)'(el_zs) + RND_HALF;
  assign az_q   = az_rnd[ROUND_SH +: RND_W];
  assign el_q   = el_rnd[ROUND_SH +: RND_W];

  always_comb begin
    az_c = az_q;
    if (az_q > AZ_LIM) az_c = AZ_LIM;
    else if (az_q < -AZ_LIM) az_c = -AZ_LIM;
    el_c = el_q;
    if (el_q > EL_LIM) el_c = EL_LIM;
    else if (el_q < -EL_LIM) el_c = -EL_LIM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= el_v;
  end

  always_ff @(posedge clk) begin
    out_az_r   <= az_c[AZ_W-1:0];
    out_el_r   <= el_c[EL_W-1:0];
    out_view_r <= el_c > RND_W'(min_el_r);
  end

  assign out_valid     = out_valid_r;
  assign out_azimuth   = out_az_r;
  assign out_elevation = out_el_r;
  assign out_in_view   = out_view_r;

  // sincos pipelines stay aligned and converge
  a_sincos_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    lat_v == lon_v) else $error("sincos pipelines out of step");

  a_sincos_resid: assert property (@(posedge clk) disable iff (!rst_n)
    lat_v |-> (lat_z <= RESID && lat_z >= -RESID && lon_z <= RESID && lon_z >= -RESID))
    else $error("sincos residual angle too large");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> ##LAT out_valid) else $error("request lost in pipeline");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> ##LAT !out_valid) else $error("result without request");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_azimuth <= AZ_LIM && out_azimuth >= -AZ_LIM &&
                   out_elevation <= EL_LIM && out_elevation >= -EL_LIM))
    else $error("angle out of range");

endmodule
